// ===== design/cfrlm_pkg.sv =====
// shared types and constants for the checksummed frame receiver
`default_nettype none

package cfrlm_pkg;

   localparam int BYTE_W = 8;
   localparam int SUM_W = 12;
   localparam int RECV_W = 32;
   localparam int FIELDS_W = 64;
   localparam int FLAGS_W = 16;
   localparam int FAIL_W = 8;
   localparam int CSR_IDX_W = 2;

   // byte positions inside a frame
   localparam int POS_HDR_FIRST = 0;
   localparam int POS_HDR_SECOND = 1;
   localparam int POS_HDR_THIRD = 2;
   localparam int POS_FIELD_FIRST = 3;
   localparam int POS_FIELD_LAST = 10;
   localparam int POS_FLAG_HI = 11;
   localparam int POS_FLAG_LO = 12;
   localparam int POS_SUM_FIRST = 13;
   localparam int POS_SUM_LAST = 16;

   localparam logic [BYTE_W-1:0] RETRY_LIMIT_RESET = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_FIRST = 2'd0,
      CSR_HEADER_SECOND = 2'd1,
      CSR_HEADER_THIRD = 2'd2,
      CSR_RETRY_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_FRAME_BYTE = 1'b0,
      OP_EMPTY_POLL = 1'b1
   } op_type;

endpackage

`default_nettype wire

// ===== design/cfrlm_req_if.sv =====
// request channel: one frame byte or one empty poll
`default_nettype none

interface cfrlm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [cfrlm_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/cfrlm_rsp_if.sv =====
// result channel: frame verdict, link state and held command values
`default_nettype none

interface cfrlm_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_ok;
   logic        link_up;
   logic [15:0] throttle;
   logic [15:0] yaw_cmd;
   logic [15:0] pitch_cmd;
   logic [15:0] roll_cmd;
   logic [7:0]  shutdown_flag;
   logic [7:0]  hold_height_flag;

   modport source (output valid, output frame_ok, output link_up, output throttle,
                   output yaw_cmd, output pitch_cmd, output roll_cmd,
                   output shutdown_flag, output hold_height_flag, input ready);
   modport sink (input valid, input frame_ok, input link_up, input throttle,
                 input yaw_cmd, input pitch_cmd, input roll_cmd,
                 input shutdown_flag, input hold_height_flag, output ready);
endinterface

`default_nettype wire

// ===== design/checksummed_frame_receiver_link_monitor.sv =====
// frame receiver with header and additive checksum checks and a link monitor
// path: the last frame byte or an empty poll passes the input register, then the response
//   register, from which its response is offered
// throughput: one request per cycle; a held response stalls all but the input register
// reset: synchronous, active high; clears frame state, held values, failure count,
//   link state (down) and both register stages; header bytes to 0, retry limit to 3
`default_nettype none

module checksummed_frame_receiver_link_monitor #(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   cfrlm_req_if.sink                                req_chan,
   cfrlm_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [cfrlm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cfrlm_pkg::BYTE_W-1:0]        csr_wdata
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam int BW = cfrlm_pkg::BYTE_W;

   // configuration registers
   logic [BW-1:0] hdr_first_ff, hdr_second_ff, hdr_third_ff, retry_limit_ff;

   // input register stage
   logic          in_valid_ff;
   logic          in_op_ff;
   logic [BW-1:0] in_byte_ff;

   // frame assembly state
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic                             frame_bad_ff, frame_bad_in;
   logic [cfrlm_pkg::SUM_W-1:0]      run_sum_ff, run_sum_in;
   logic [cfrlm_pkg::RECV_W-1:0]     recv_sum_ff, recv_sum_in;
   logic [cfrlm_pkg::FIELDS_W-1:0]   staged_fields_ff, staged_fields_in;
   logic [cfrlm_pkg::FLAGS_W-1:0]    staged_flags_ff, staged_flags_in;

   // held command values and link monitor
   logic [cfrlm_pkg::FIELDS_W-1:0]   held_fields_ff, held_fields_in;
   logic [cfrlm_pkg::FLAGS_W-1:0]    held_flags_ff, held_flags_in;
   logic [cfrlm_pkg::FAIL_W-1:0]     fail_cnt_ff, fail_cnt_in;
   logic                             link_ff, link_in;

   // response register
   logic                             rsp_valid_ff;
   logic                             rsp_ok_ff;
   logic                             rsp_link_ff;
   logic [cfrlm_pkg::FIELDS_W-1:0]   rsp_fields_ff;
   logic [cfrlm_pkg::FLAGS_W-1:0]    rsp_flags_ff;

   logic                             advance;
   logic                             fire;
   logic                             emit;
   logic                             ok;
   logic                             sum_match;
   logic [2:0]                       fld_idx;
   logic [1:0]                       sum_idx;
   logic [cfrlm_pkg::FAIL_W-1:0]     fail_plus;

   // the response register frees up when empty or being taken this cycle
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign fire = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   // byte slot within the staged command word and the checksum word
   assign fld_idx = 3'(pos_ff - POS_W'(cfrlm_pkg::POS_FIELD_FIRST));
   assign sum_idx = 2'(pos_ff - POS_W'(cfrlm_pkg::POS_SUM_FIRST));
   assign fail_plus = fail_cnt_ff + cfrlm_pkg::FAIL_W'(1);

   always_comb begin
      pos_in = pos_ff;
      frame_bad_in = frame_bad_ff;
      run_sum_in = run_sum_ff;
      recv_sum_in = recv_sum_ff;
      staged_fields_in = staged_fields_ff;
      staged_flags_in = staged_flags_ff;
      held_fields_in = held_fields_ff;
      held_flags_in = held_flags_ff;
      fail_cnt_in = fail_cnt_ff;
      link_in = link_ff;
      emit = 1'b0;
      ok = 1'b0;
      sum_match = 1'b0;

      if (fire) begin
         if (in_op_ff == cfrlm_pkg::OP_EMPTY_POLL) begin
            // empty poll drops any partial frame and counts as a failure
            emit = 1'b1;
         end else begin
            // header checks, byte 0 must also be non-zero
            if (pos_ff == POS_W'(cfrlm_pkg::POS_HDR_FIRST) &&
                (in_byte_ff == '0 || in_byte_ff != hdr_first_ff)) begin
               frame_bad_in = 1'b1;
            end
            if (pos_ff == POS_W'(cfrlm_pkg::POS_HDR_SECOND) && in_byte_ff != hdr_second_ff) begin
               frame_bad_in = 1'b1;
            end
            if (pos_ff == POS_W'(cfrlm_pkg::POS_HDR_THIRD) && in_byte_ff != hdr_third_ff) begin
               frame_bad_in = 1'b1;
            end
            // additive checksum over bytes 0..12, kept to 12 bits
            if (pos_ff < POS_W'(cfrlm_pkg::POS_SUM_FIRST)) begin
               run_sum_in = run_sum_ff + cfrlm_pkg::SUM_W'(in_byte_ff);
            end
            // command fields, big-endian
            if (pos_ff >= POS_W'(cfrlm_pkg::POS_FIELD_FIRST) &&
                pos_ff <= POS_W'(cfrlm_pkg::POS_FIELD_LAST)) begin
               staged_fields_in[BW*(7 - int'(fld_idx)) +: BW] = in_byte_ff;
            end
            if (pos_ff == POS_W'(cfrlm_pkg::POS_FLAG_HI)) begin
               staged_flags_in[BW +: BW] = in_byte_ff;
            end
            if (pos_ff == POS_W'(cfrlm_pkg::POS_FLAG_LO)) begin
               staged_flags_in[0 +: BW] = in_byte_ff;
            end
            // transmitted checksum word, big-endian
            if (pos_ff >= POS_W'(cfrlm_pkg::POS_SUM_FIRST) &&
                pos_ff <= POS_W'(cfrlm_pkg::POS_SUM_LAST)) begin
               recv_sum_in[BW*(3 - int'(sum_idx)) +: BW] = in_byte_ff;
            end

            if (pos_ff == LAST_POS) begin
               // last byte: judge the frame on the updated values
               sum_match = (cfrlm_pkg::RECV_W'(run_sum_in) == recv_sum_in);
               ok = !frame_bad_in && sum_match;
               if (ok) begin
                  held_fields_in = staged_fields_in;
                  held_flags_in = staged_flags_in;
               end
               emit = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end

         if (emit) begin
            // frame finished or poll: start a fresh frame
            pos_in = '0;
            frame_bad_in = 1'b0;
            run_sum_in = '0;
            recv_sum_in = '0;
            staged_fields_in = '0;
            staged_flags_in = '0;
            // link monitor
            if (ok) begin
               link_in = 1'b1;
               fail_cnt_in = '0;
            end else if (fail_plus >= retry_limit_ff) begin
               link_in = 1'b0;
               fail_cnt_in = '0;
            end else begin
               fail_cnt_in = fail_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff <= '0;
         hdr_second_ff <= '0;
         hdr_third_ff <= '0;
         retry_limit_ff <= cfrlm_pkg::RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (cfrlm_pkg::csr_index_type'(csr_index))
            cfrlm_pkg::CSR_HEADER_FIRST: hdr_first_ff <= csr_wdata;
            cfrlm_pkg::CSR_HEADER_SECOND: hdr_second_ff <= csr_wdata;
            cfrlm_pkg::CSR_HEADER_THIRD: hdr_third_ff <= csr_wdata;
            cfrlm_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff <= req_chan.op;
         in_byte_ff <= req_chan.data_byte;
      end
   end

   // frame and link state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         frame_bad_ff <= 1'b0;
         run_sum_ff <= '0;
         recv_sum_ff <= '0;
         staged_fields_ff <= '0;
         staged_flags_ff <= '0;
         held_fields_ff <= '0;
         held_flags_ff <= '0;
         fail_cnt_ff <= '0;
         link_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         frame_bad_ff <= frame_bad_in;
         run_sum_ff <= run_sum_in;
         recv_sum_ff <= recv_sum_in;
         staged_fields_ff <= staged_fields_in;
         staged_flags_ff <= staged_flags_in;
         held_fields_ff <= held_fields_in;
         held_flags_ff <= held_flags_in;
         fail_cnt_ff <= fail_cnt_in;
         link_ff <= link_in;
      end
   end

   // response register, reports the held values after this request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_ok_ff <= ok;
         rsp_link_ff <= link_in;
         rsp_fields_ff <= held_fields_in;
         rsp_flags_ff <= held_flags_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.frame_ok = rsp_ok_ff;
   assign rsp_chan.link_up = rsp_link_ff;
   assign rsp_chan.throttle = rsp_fields_ff[63:48];
   assign rsp_chan.yaw_cmd = rsp_fields_ff[47:32];
   assign rsp_chan.pitch_cmd = rsp_fields_ff[31:16];
   assign rsp_chan.roll_cmd = rsp_fields_ff[15:0];
   assign rsp_chan.shutdown_flag = rsp_flags_ff[15:8];
   assign rsp_chan.hold_height_flag = rsp_flags_ff[7:0];

endmodule

`default_nettype wire

// ===== design/cfrlm_checker.sv =====
// port-level checks for the frame receiver, bound to the top level
`default_nettype none

module cfrlm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_frame_ok,
   input wire logic        rsp_link_up,
   input wire logic [15:0] rsp_throttle
);

   // a good frame always brings the link up
   a_ok_means_link_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_link_up)
      else $error("frame_ok without link_up");

   // nothing left over in either stage after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("stage not empty after reset");

   // with no response pending the block never stalls requests
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> req_ready)
      else $error("request side stalled with nothing queued");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_ok) &&
      $stable(rsp_link_up) && $stable(rsp_throttle))
      else $error("stalled response changed");

endmodule

bind checksummed_frame_receiver_link_monitor cfrlm_checker u_cfrlm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_frame_ok(rsp_chan.frame_ok),
   .rsp_link_up(rsp_chan.link_up),
   .rsp_throttle(rsp_chan.throttle)
);

`default_nettype wire
